@@ rtl/dss_pkg.sv @@
// Shared constants, codes and command/status types of the drum step sequencer.
package dss_pkg;

  localparam int NUM_ROWS  = 8;
  localparam int NUM_STEPS = 16;

  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int STEP_W = $clog2(NUM_STEPS);
  localparam int CNT_W  = 25;
  localparam int PER_W  = 24;
  localparam int NOTE_W = 7;
  localparam int CHAN_W = 5;
  localparam int CFG_IDX_W = 3;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_EXTRA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_NOTE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 3'd4;

  // Reset values of the registers
  localparam logic [PER_W-1:0]  RST_STEP_PERIOD = 24'd100;
  localparam logic [PER_W-1:0]  RST_SWING_EXTRA = 24'd33;
  localparam logic [NOTE_W-1:0] RST_BASE_NOTE   = 7'd35;
  localparam logic [NOTE_W-1:0] RST_VELOCITY    = 7'd100;
  localparam logic [CHAN_W-1:0] RST_CHANNEL     = 5'd1;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

  // Event kinds
  localparam logic EV_ALL_OFF = 1'b0;
  localparam logic EV_NOTE_ON = 1'b1;

  typedef struct packed {
    logic write_cell;  // set or clear one grid cell
    logic tick_dec;    // count one tick down
    logic fire;        // latch the step's row mask, reload countdown, advance step
    logic emit_off;    // issue the all-notes-off item
    logic emit_note;   // issue the note-on of the lowest pending row
  } dss_cmd_t;

  typedef struct packed {
    logic cnt_zero;    // countdown has expired
    logic pend_empty;  // no rows left to play
    logic pend_last;   // at most one row left to play
  } dss_stat_t;

endpackage

@@ rtl/dss_ctrl.sv @@
// Controller state machine of the drum step sequencer.
module dss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  dss_pkg::dss_stat_t stat,
  output dss_pkg::dss_cmd_t  cmd,
  output logic               busy
);
  import dss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFF,
    ST_NOTES
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_SET, REQ_CLEAR: cmd.write_cell = 1'b1;
            REQ_TICK: begin
              if (stat.cnt_zero) begin
                cmd.fire  = 1'b1;
                state_nxt = ST_OFF;
              end else begin
                cmd.tick_dec = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_OFF: begin
        cmd.emit_off = 1'b1;
        state_nxt    = stat.pend_empty ? ST_IDLE : ST_NOTES;
      end
      ST_NOTES: begin
        cmd.emit_note = 1'b1;
        if (stat.pend_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/dss_dp.sv @@
// Datapath of the drum step sequencer: registers, grid, countdown and event output.
module dss_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dss_pkg::dss_cmd_t          cmd,
  output dss_pkg::dss_stat_t         stat,
  input  logic [1:0]                 req_type,
  input  logic [2:0]                 row,
  input  logic [3:0]                 step_col,
  input  logic                       cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::PER_W-1:0]  cfg_data,
  output logic                       out_valid,
  output logic                       out_event_kind,
  output logic [6:0]                 out_note,
  output logic [6:0]                 out_velocity,
  output logic [4:0]                 out_channel,
  output logic [3:0]                 out_played_step,
  output logic                       out_last
);
  import dss_pkg::*;

  logic [PER_W-1:0]    step_period_r, swing_extra_r;
  logic [NOTE_W-1:0]   base_note_r, velocity_r;
  logic [CHAN_W-1:0]   channel_r;

  logic [NUM_ROWS-1:0] grid_r [NUM_STEPS];
  logic [STEP_W-1:0]   cur_step_r, fired_step_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [NUM_ROWS-1:0] pend_r;

  logic                out_valid_r, out_kind_r, out_last_r;
  logic [NOTE_W-1:0]   out_note_r, out_vel_r;
  logic [CHAN_W-1:0]   out_chan_r;
  logic [STEP_W-1:0]   out_step_r;

  logic [ROW_W-1:0]    low_row;
  logic [NUM_ROWS-1:0] pend_after;
  logic [NOTE_W:0]     note_sum;
  logic [NOTE_W-1:0]   note_sat;
  logic [CNT_W-1:0]    interval;
  logic                cell_ok;

  // Lowest pending row
  always_comb begin
    low_row = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (pend_r[r]) begin
        low_row = ROW_W'(r);
      end
    end
  end

  assign pend_after = pend_r & (pend_r - NUM_ROWS'(1));
  assign note_sum   = {1'b0, base_note_r} + (NOTE_W + 1)'(1) + (NOTE_W + 1)'(low_row);
  assign note_sat   = (note_sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : note_sum[NOTE_W-1:0];

  // Swing lengthens the interval after even step indexes
  assign interval = {1'b0, step_period_r} +
                    (cur_step_r[0] ? CNT_W'(0) : {1'b0, swing_extra_r});

  assign cell_ok = (32'(row) < NUM_ROWS) && (32'(step_col) < NUM_STEPS);

  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.pend_empty = (pend_r == '0);
  assign stat.pend_last  = (pend_after == '0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= RST_STEP_PERIOD;
      swing_extra_r <= RST_SWING_EXTRA;
      base_note_r   <= RST_BASE_NOTE;
      velocity_r    <= RST_VELOCITY;
      channel_r     <= RST_CHANNEL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_PERIOD: step_period_r <= cfg_data;
        CFG_SWING_EXTRA: swing_extra_r <= cfg_data;
        CFG_BASE_NOTE:   base_note_r   <= cfg_data[NOTE_W-1:0];
        CFG_VELOCITY:    velocity_r    <= cfg_data[NOTE_W-1:0];
        CFG_CHANNEL:     channel_r     <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid, countdown and step state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STEPS; s++) begin
        grid_r[s] <= '0;
      end
      cur_step_r <= '0;
      cnt_r      <= '0;
      pend_r     <= '0;
    end else begin
      if (cmd.write_cell && cell_ok) begin
        grid_r[step_col[STEP_W-1:0]][row[ROW_W-1:0]] <= (req_type == REQ_SET);
      end
      if (cmd.tick_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.fire) begin
        pend_r       <= grid_r[cur_step_r];
        fired_step_r <= cur_step_r;
        cnt_r        <= (interval == '0) ? '0 : interval - CNT_W'(1);
        cur_step_r   <= (32'(cur_step_r) == NUM_STEPS - 1) ? '0
                                                             : cur_step_r + STEP_W'(1);
      end
      if (cmd.emit_note) begin
        pend_r <= pend_after;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_off || cmd.emit_note;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_off) begin
      out_kind_r <= EV_ALL_OFF;
      out_note_r <= '0;
      out_vel_r  <= '0;
      out_last_r <= (pend_r == '0);
    end else if (cmd.emit_note) begin
      out_kind_r <= EV_NOTE_ON;
      out_note_r <= note_sat;
      out_vel_r  <= velocity_r;
      out_last_r <= (pend_after == '0);
    end
    if (cmd.emit_off || cmd.emit_note) begin
      out_chan_r <= channel_r;
      out_step_r <= fired_step_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_note        = out_note_r;
  assign out_velocity    = out_vel_r;
  assign out_channel     = out_chan_r;
  assign out_played_step = out_step_r;
  assign out_last        = out_last_r;

endmodule

@@ rtl/drum_step_sequencer_swing.sv @@
// Top level of the drum step sequencer with swing.
// A set, clear or non-firing tick item updates the block and gives no result item.
// A firing tick gives its all-notes-off item via the ST_OFF state and the output
// register, then one note-on item per cycle; busy stays high in ST_OFF and ST_NOTES.
// A new request is accepted only after the one-row-per-cycle emit loop has ended.
// Reset (rst_n, synchronous): grid cleared, step 0, countdown 0, registers to defaults.
module drum_step_sequencer_swing (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_row,
  input  logic [3:0]  in_step_col,
  // result channel: one item per strobe, the receiver cannot stall
  output logic        out_valid,
  output logic        out_event_kind,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [4:0]  out_channel,
  output logic [3:0]  out_played_step,
  output logic        out_last,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import dss_pkg::*;

  dss_cmd_t  cmd;
  dss_stat_t stat;

  // Registers are always writable; writes must arrive only while the block is idle, which it does not enforce
  assign cfg_ready = 1'b1;

  // Controller: decode the accepted item and sequence the emit run
  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Datapath: hold the grid, countdown, step and registers; drive result items
  dss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (in_req_type),
    .row             (in_row),
    .step_col        (in_step_col),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_event_kind  (out_event_kind),
    .out_note        (out_note),
    .out_velocity    (out_velocity),
    .out_channel     (out_channel),
    .out_played_step (out_played_step),
    .out_last        (out_last)
  );

endmodule
